/* design/mlfd_pkg.sv */
// Types and constants shared by the marker/length frame decoder.
package mlfd_pkg;

  // Decoder phase.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_ERR  = 3'd3,
    PH_CHK  = 3'd4,
    PH_PAY  = 3'd5,
    PH_END  = 3'd6
  } phase_t;

  // Frame-end status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ERRCODE = 3'd1;
  localparam logic [2:0] ST_CHECK   = 3'd2;
  localparam logic [2:0] ST_BADEND  = 3'd3;
  localparam logic [2:0] ST_TOOLONG = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN      = 2'd2;

  // Output kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // Widths of the result transfer.
  localparam int unsigned OUT_BITS  = 107;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] cmd_id;
    logic [31:0] frame_err_code;
    logic [31:0] check_word;
    logic [2:0]  status;
  } result_t;

endpackage

/* design/marker_length_frame_decoder.sv */
// Marker/length frame decoder: start-marker hunt, header gathering, payload pass and end check.
//
//   channel   direction  fields
//   in_       slave      tdata: in_byte[7:0]
//   out_      master     tdata: data_byte, cmd_id, frame_err_code, check_word, status;
//                        tlast: kind (frame-end report)
//   cfg_      write      0 start_marker, 1 end_marker, 2 max_payload_len
//
// The decoder state and the result buffer update at the edge on which the byte is
// transferred, so one byte is taken per clock while in_tready is high.
// A result is registered into the output register, or into the skid register while it is full.
// A two-entry result buffer (output register plus skid register) lets a byte be taken
// while a result waits; in_tready falls only when both entries are full.
// Reset is synchronous and active low; it returns to the start-marker hunt.
module marker_length_frame_decoder (
  input  logic          clk,
  input  logic          rst_n,
  // Input stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] in_byte
  // Result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [mlfd_pkg::OUT_BYTES*8-1:0] out_tdata,
  // [7:0] data_byte, [39:8] cmd_id, [71:40] frame_err_code,
  // [103:72] check_word, [106:104] status, upper bits zero
  output logic          out_tlast,  // kind: high on a frame-end report
  // Configuration
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata
);

  // Configuration registers
  logic [15:0] start_marker_r;
  logic [15:0] end_marker_r;
  logic [15:0] max_len_r;

  // Decoder state
  mlfd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [31:0] cmd_id_r, cmd_id_nxt;
  logic [31:0] err_code_r, err_code_nxt;
  logic [31:0] check_r, check_nxt;
  logic [15:0] remaining_r, remaining_nxt;

  // Result buffer
  mlfd_pkg::result_t out_r, skid_r, res;
  logic        out_vld_r, skid_vld_r;
  logic        res_vld;

  logic        in_xfer;
  logic        out_xfer;
  logic [31:0] shifted;
  logic [15:0] pair;

  assign in_tready = !skid_vld_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign shifted   = {gather_r[23:0], in_tdata};
  assign pair      = {held_byte_r, in_tdata};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= 16'h0000;
      end_marker_r   <= 16'h0000;
      max_len_r      <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_addr)
        mlfd_pkg::CFG_START_MARKER: start_marker_r <= cfg_wdata;
        mlfd_pkg::CFG_END_MARKER:   end_marker_r   <= cfg_wdata;
        mlfd_pkg::CFG_MAX_LEN:      max_len_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state of the decoder for the byte on the input.
  always_comb begin
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    gather_nxt     = gather_r;
    cmd_id_nxt     = cmd_id_r;
    err_code_nxt   = err_code_r;
    check_nxt      = check_r;
    remaining_nxt  = remaining_r;
    unique case (phase_r)
      mlfd_pkg::PH_CMD, mlfd_pkg::PH_LEN, mlfd_pkg::PH_ERR, mlfd_pkg::PH_CHK: begin
        gather_nxt = shifted;
        if (count_r != 2'd3) begin
          count_nxt = count_r + 2'd1;
        end else begin
          count_nxt = 2'd0;
          unique case (phase_r)
            mlfd_pkg::PH_CMD: begin
              cmd_id_nxt = shifted;
              phase_nxt  = mlfd_pkg::PH_LEN;
            end
            mlfd_pkg::PH_LEN: begin
              if (shifted > {16'h0000, max_len_r}) begin
                phase_nxt      = mlfd_pkg::PH_HUNT;
                held_valid_nxt = 1'b0;
              end else begin
                remaining_nxt = shifted[15:0];
                phase_nxt     = mlfd_pkg::PH_ERR;
              end
            end
            mlfd_pkg::PH_ERR: begin
              err_code_nxt = shifted;
              phase_nxt    = mlfd_pkg::PH_CHK;
            end
            default: begin
              check_nxt      = shifted;
              held_valid_nxt = 1'b0;
              phase_nxt      = (remaining_r != 16'd0) ? mlfd_pkg::PH_PAY : mlfd_pkg::PH_END;
            end
          endcase
        end
      end
      mlfd_pkg::PH_PAY: begin
        remaining_nxt = remaining_r - 16'd1;
        if (remaining_r == 16'd1) begin
          held_valid_nxt = 1'b0;
          phase_nxt      = mlfd_pkg::PH_END;
        end
      end
      mlfd_pkg::PH_END: begin
        if (!held_valid_r) begin
          held_byte_nxt  = in_tdata;
          held_valid_nxt = 1'b1;
        end else begin
          phase_nxt = mlfd_pkg::PH_HUNT;
          if (pair == end_marker_r) begin
            held_valid_nxt = 1'b0;
          end else begin
            held_byte_nxt  = in_tdata;
            held_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = mlfd_pkg::PH_HUNT;
        if (held_valid_r && (pair == start_marker_r)) begin
          held_valid_nxt = 1'b0;
          count_nxt      = 2'd0;
          gather_nxt     = 32'd0;
          err_code_nxt   = 32'd0;
          check_nxt      = 32'd0;
          phase_nxt      = mlfd_pkg::PH_CMD;
        end else begin
          held_byte_nxt  = in_tdata;
          held_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  // Result caused by the byte on the input, if any.
  always_comb begin
    res_vld            = 1'b0;
    res.kind           = mlfd_pkg::KIND_REPORT;
    res.data_byte      = 8'h00;
    res.cmd_id         = cmd_id_r;
    res.frame_err_code = err_code_r;
    res.check_word     = check_r;
    res.status         = mlfd_pkg::ST_OK;
    unique case (phase_r)
      mlfd_pkg::PH_LEN: begin
        // Oversized frame: report before the error code and check word arrive.
        if ((count_r == 2'd3) && (shifted > {16'h0000, max_len_r})) begin
          res_vld            = 1'b1;
          res.frame_err_code = 32'd0;
          res.check_word     = 32'd0;
          res.status         = mlfd_pkg::ST_TOOLONG;
        end
      end
      mlfd_pkg::PH_PAY: begin
        res_vld       = 1'b1;
        res.kind      = mlfd_pkg::KIND_PAYLOAD;
        res.data_byte = in_tdata;
      end
      mlfd_pkg::PH_END: begin
        if (held_valid_r) begin
          res_vld = 1'b1;
          priority if (pair != end_marker_r) begin
            res.status = mlfd_pkg::ST_BADEND;
          end else if (err_code_r != 32'd0) begin
            res.status = mlfd_pkg::ST_ERRCODE;
          end else if (check_r != 32'd0) begin
            res.status = mlfd_pkg::ST_CHECK;
          end else begin
            res.status = mlfd_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // Decoder state registers, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mlfd_pkg::PH_HUNT;
      count_r      <= 2'd0;
      held_byte_r  <= 8'h00;
      held_valid_r <= 1'b0;
      gather_r     <= 32'd0;
      cmd_id_r     <= 32'd0;
      err_code_r   <= 32'd0;
      check_r      <= 32'd0;
      remaining_r  <= 16'd0;
    end else if (in_xfer) begin
      phase_r      <= phase_nxt;
      count_r      <= count_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      gather_r     <= gather_nxt;
      cmd_id_r     <= cmd_id_nxt;
      err_code_r   <= err_code_nxt;
      check_r      <= check_nxt;
      remaining_r  <= remaining_nxt;
    end
  end

  // Output register and skid register, kept in arrival order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_xfer) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_xfer && res_vld;
      end
    end else if (in_xfer && res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_xfer) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (in_xfer && res_vld) begin
      skid_r <= res;
    end
  end

  // Result port packing.
  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_r.kind;
  assign out_tdata  = {{(mlfd_pkg::OUT_BYTES*8 - mlfd_pkg::OUT_BITS){1'b0}},
                       out_r.status, out_r.check_word, out_r.frame_err_code,
                       out_r.cmd_id, out_r.data_byte};

  // The skid register is only ever filled behind a full output register.
  assert property (@(posedge clk) disable iff (!rst_n) skid_vld_r |-> out_vld_r)
    else $error("skid entry held without an output entry");

  // The payload phase always has bytes left to pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mlfd_pkg::PH_PAY) |-> (remaining_r != 16'd0))
    else $error("payload phase with no bytes remaining");

  // Payload results carry status ok; reports carry a zero data byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_r.status == mlfd_pkg::ST_OK))
    else $error("payload result with nonzero status");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_r.data_byte == 8'h00))
    else $error("frame-end report with nonzero data byte");

endmodule

/* test/tb_marker_length_frame_decoder.sv */
// Self-checking testbench for the marker/length frame decoder with a frame-level predictor.
`timescale 1ns / 100ps

// Tracks the decoder's parse state for every byte transfer into the block.
// It also holds the queue of outputs that the decoder still owes.
class frame_tracker;
  logic [15:0] sync_word;
  logic [15:0] close_word;
  logic [15:0] len_limit;

  mlfd_pkg::phase_t stage;
  logic [1:0]  byte_pos;
  logic [7:0]  kept_byte;
  logic        kept_valid;
  logic [31:0] shift_acc;
  logic [31:0] hdr_cmd;
  logic [31:0] hdr_err;
  logic [31:0] hdr_chk;
  logic [31:0] bytes_left;

  mlfd_pkg::result_t frame_outputs[$];
  int          failures;

  function new();
    sync_word  = 16'h0000;
    close_word = 16'h0000;
    len_limit  = 16'hFFFF;
    stage      = mlfd_pkg::PH_HUNT;
    byte_pos   = 2'd0;
    kept_byte  = 8'h00;
    kept_valid = 1'b0;
    shift_acc  = 32'h0;
    hdr_cmd    = 32'h0;
    hdr_err    = 32'h0;
    hdr_chk    = 32'h0;
    bytes_left = 32'h0;
    failures   = 0;
  endfunction

  function void set_reg(logic [1:0] addr, logic [15:0] value);
    case (addr)
      mlfd_pkg::CFG_START_MARKER: sync_word  = value;
      mlfd_pkg::CFG_END_MARKER:   close_word = value;
      mlfd_pkg::CFG_MAX_LEN:      len_limit  = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return frame_outputs.size();
  endfunction

  function void post(logic kind, logic [7:0] data, logic [31:0] err, logic [31:0] chk,
                     logic [2:0] st);
    mlfd_pkg::result_t r;
    r.kind           = kind;
    r.data_byte      = data;
    r.cmd_id         = hdr_cmd;
    r.frame_err_code = err;
    r.check_word     = chk;
    r.status         = st;
    frame_outputs.push_back(r);
  endfunction

  // Advance the parse by one accepted byte.
  function void take_byte(logic [7:0] b);
    logic [2:0] st;
    case (stage)
      mlfd_pkg::PH_CMD, mlfd_pkg::PH_LEN, mlfd_pkg::PH_ERR, mlfd_pkg::PH_CHK: begin
        shift_acc = {shift_acc[23:0], b};
        if (byte_pos != 2'd3) begin
          byte_pos++;
        end else begin
          byte_pos = 2'd0;
          case (stage)
            mlfd_pkg::PH_CMD: begin
              hdr_cmd = shift_acc;
              stage   = mlfd_pkg::PH_LEN;
            end
            mlfd_pkg::PH_LEN: begin
              // An oversized length is reported at once and the frame abandoned.
              if (shift_acc > {16'h0000, len_limit}) begin
                post(mlfd_pkg::KIND_REPORT, 8'h00, 32'h0, 32'h0, mlfd_pkg::ST_TOOLONG);
                stage      = mlfd_pkg::PH_HUNT;
                kept_valid = 1'b0;
              end else begin
                bytes_left = shift_acc;
                stage      = mlfd_pkg::PH_ERR;
              end
            end
            mlfd_pkg::PH_ERR: begin
              hdr_err = shift_acc;
              stage   = mlfd_pkg::PH_CHK;
            end
            default: begin
              hdr_chk    = shift_acc;
              kept_valid = 1'b0;
              stage      = (bytes_left != 32'h0) ? mlfd_pkg::PH_PAY : mlfd_pkg::PH_END;
            end
          endcase
        end
      end
      mlfd_pkg::PH_PAY: begin
        post(mlfd_pkg::KIND_PAYLOAD, b, hdr_err, hdr_chk, mlfd_pkg::ST_OK);
        bytes_left--;
        if (bytes_left == 32'h0) begin
          kept_valid = 1'b0;
          stage      = mlfd_pkg::PH_END;
        end
      end
      mlfd_pkg::PH_END: begin
        if (!kept_valid) begin
          kept_byte  = b;
          kept_valid = 1'b1;
        end else begin
          stage = mlfd_pkg::PH_HUNT;
          if ({kept_byte, b} == close_word) begin
            // The error code outranks the check word.
            st = (hdr_err != 32'h0) ? mlfd_pkg::ST_ERRCODE :
                 (hdr_chk != 32'h0) ? mlfd_pkg::ST_CHECK : mlfd_pkg::ST_OK;
            post(mlfd_pkg::KIND_REPORT, 8'h00, hdr_err, hdr_chk, st);
            kept_valid = 1'b0;
          end else begin
            // A bad end keeps its second byte as the first candidate of the next hunt.
            post(mlfd_pkg::KIND_REPORT, 8'h00, hdr_err, hdr_chk, mlfd_pkg::ST_BADEND);
            kept_byte  = b;
            kept_valid = 1'b1;
          end
        end
      end
      default: begin
        stage = mlfd_pkg::PH_HUNT;
        if (kept_valid && {kept_byte, b} == sync_word) begin
          kept_valid = 1'b0;
          byte_pos   = 2'd0;
          shift_acc  = 32'h0;
          hdr_err    = 32'h0;
          hdr_chk    = 32'h0;
          stage      = mlfd_pkg::PH_CMD;
        end else begin
          kept_byte  = b;
          kept_valid = 1'b1;
        end
      end
    endcase
  endfunction

  function void compare(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      failures++;
    end
  endfunction

  // Compare one output transfer with the oldest owed output.
  function void match_output(logic [mlfd_pkg::OUT_BYTES*8-1:0] tdata, logic last);
    mlfd_pkg::result_t want;
    if (frame_outputs.size() == 0) begin
      $display("%0t: unexpected output: expected none, actual tlast %b tdata %h",
               $time, last, tdata);
      failures++;
    end else begin
      want = frame_outputs.pop_front();
      compare("kind", 32'(want.kind), 32'(last));
      compare("data_byte", 32'(want.data_byte), 32'(tdata[7:0]));
      compare("cmd_id", want.cmd_id, tdata[39:8]);
      compare("frame_err_code", want.frame_err_code, tdata[71:40]);
      compare("check_word", want.check_word, tdata[103:72]);
      compare("status", 32'(want.status), 32'(tdata[106:104]));
      compare("padding", 32'h0,
              32'(tdata[mlfd_pkg::OUT_BYTES*8-1:mlfd_pkg::OUT_BITS]));
    end
  endfunction
endclass

module tb_marker_length_frame_decoder;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned PHASE_BYTES   = 125;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [7:0]              in_tdata   = 8'h00;  // [7:0] in_byte
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [mlfd_pkg::OUT_BYTES*8-1:0] out_tdata;  // [7:0] data_byte, [39:8] cmd_id,
                                                // [71:40] frame_err_code,
                                                // [103:72] check_word, [106:104] status
  logic                    out_tlast;           // kind
  logic                    cfg_we     = 1'b0;
  logic [1:0]              cfg_addr   = mlfd_pkg::CFG_START_MARKER;
  logic [15:0]             cfg_wdata  = 16'h0000;

  frame_tracker tracker = new();
  bit           in_gaps = 1'b1;
  bit           calm    = 1'b0;
  int           stall_left = 0;
  int unsigned  cycles     = 0;
  int unsigned  bytes_sent = 0;

  marker_length_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_marker_length_frame_decoder failed");
      $finish;
    end
  end

  // Output side: check each transfer and apply random back-pressure bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_output(out_tdata, out_tlast);
    end
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One byte transfer, with an occasional gap before it.
  task automatic send_byte(logic [7:0] b);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_half(logic [15:0] h);
    send_byte(h[15:8]);
    send_byte(h[7:0]);
  endtask

  task automatic send_word(logic [31:0] w);
    send_half(w[31:16]);
    send_half(w[15:0]);
  endtask

  // Hold the input back until every owed output has been transferred.
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic load_config(logic [15:0] sync_v, logic [15:0] close_v, logic [15:0] limit_v);
    logic [1:0]  addrs [3];
    logic [15:0] vals  [3];
    addrs = '{mlfd_pkg::CFG_START_MARKER, mlfd_pkg::CFG_END_MARKER, mlfd_pkg::CFG_MAX_LEN};
    vals  = '{sync_v, close_v, limit_v};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      tracker.set_reg(addrs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] header_word(int unsigned zero_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < zero_pct) return 32'h0;
    if (pick < zero_pct + 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // One frame, mostly well formed, with noise, cut markers, oversize lengths and bad ends.
  task automatic send_frame();
    int unsigned pick;
    int unsigned len_cap;
    int unsigned len;
    logic [31:0] len_word;
    logic [31:0] err_word;
    logic [31:0] chk_word;
    logic [15:0] tail;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    end else if (pick < 18) begin
      send_byte(tracker.sync_word[15:8]);
      send_byte(8'($urandom));
    end
    pick = $urandom_range(0, 99);
    send_half(tracker.sync_word);
    send_word($urandom);
    if (pick < 10) begin
      len_word = $urandom;
      if (len_word <= {16'h0000, tracker.len_limit}) begin
        len_word = {16'h0000, tracker.len_limit} + 32'd1;
      end
      send_word(len_word);
    end else begin
      len_cap = (pick < 22) ? 40 : 6;
      if (len_cap > tracker.len_limit) len_cap = tracker.len_limit;
      len      = $urandom_range(0, len_cap);
      err_word = header_word(65);
      chk_word = header_word(45);
      send_word(len);
      send_word(err_word);
      send_word(chk_word);
      repeat (len) send_byte(8'($urandom));
      tail = tracker.close_word;
      if ($urandom_range(0, 99) < 12) tail = tail ^ 16'($urandom_range(1, 16'hFFFF));
      send_half(tail);
    end
  endtask

  // Main sequence: reset, directed frames, then phases of random frames.
  initial begin
    int unsigned phase_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: a slipped start, an oversize length with all
    // header bits set, then an empty frame whose end marker is wrong.
    send_byte(8'h5A);
    send_half(16'h0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_half(16'h0000);
    repeat (4) send_word(32'h0);
    send_half(16'h00FF);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (p)
          1: load_config(16'hFFFF, 16'hFFFF, 16'h0000);
          2: load_config(16'($urandom), 16'($urandom), 16'hFFFF);
          3: load_config(16'($urandom), 16'($urandom), 16'($urandom_range(1, 12)));
          4: load_config(16'($urandom), 16'($urandom), 16'($urandom));
          default: load_config(16'($urandom), 16'($urandom), 16'd40);
        endcase
      end
      in_gaps = (p != 5);
      calm    = (p == 5);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_frame();
        if ($urandom_range(0, 29) == 0) drain_outputs();
      end
    end

    // Let the last outputs through, then give the verdict.
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("tb_marker_length_frame_decoder passed");
    end else begin
      $display("tb_marker_length_frame_decoder failed");
    end
    $finish;
  end

endmodule
